@@ hdl/arwc_pkg.sv @@
// shared types, widths and helpers for the arm reach workspace clamp
package arwc_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int ROOT_W      = COORD_WIDTH + 1;      // distance bits
  localparam int RAD_W       = 2 * ROOT_W;           // sum of squares bits
  localparam int PROD_W      = 2 * COORD_WIDTH + 1;  // |v| * t bits
  localparam int SUM_W       = PROD_W + 2;           // signed result before saturation
  localparam int ADDR_W      = 5;
  localparam int TOL_W       = 8;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COORD_WIDTH:0]   delta_t;

  typedef struct packed {
    coord_t target_x;
    coord_t target_y;
    coord_t target_z;
  } target_t;

  typedef struct packed {
    coord_t result_x;
    coord_t result_y;
    coord_t result_z;
    logic   out_of_bounds;
  } result_t;

  typedef struct packed {
    logic [COORD_WIDTH-2:0] l1;
    logic [COORD_WIDTH-2:0] l2;
    coord_t                 shoulder;
    coord_t                 z_lo;
    coord_t                 z_hi;
    logic [TOL_W-1:0]       tol;
  } cfg_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    delta_t dz;
    logic   zbad;
  } root_side_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   neg_x;
    logic   neg_y;
    logic   neg_z;
    logic   scale;
    logic   oob;
  } div_side_t;

  typedef enum logic [2:0] {
    REG_LINK_ONE  = 3'd0,
    REG_LINK_TWO  = 3'd1,
    REG_SHOULDER  = 3'd2,
    REG_Z_LOWER   = 3'd3,
    REG_Z_UPPER   = 3'd4,
    REG_TOLERANCE = 3'd5
  } reg_idx_t;

  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) return coord_t'(hi);
    if (v < lo) return coord_t'(lo);
    return coord_t'(v);
  endfunction

endpackage

@@ hdl/arm_reach_workspace_clamp_top.sv @@
// top level of the arm reach workspace clamp
// Accepts one target item per clock (busy never rises) and returns its result
// flagged by done for one cycle, after it has passed the bit-per-stage square
// root (COORD_WIDTH+1 stages) and the bit-per-stage divider (2*COORD_WIDTH+1
// stages). Results cannot be held off, so take them in the cycle done is high.
// Configure only while no item is in flight.
module arm_reach_workspace_clamp_top
  import arwc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  target_t           target,
  output logic              done,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;

  arwc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign busy = 1'b0;

  // stage 1: capture item
  logic    v1;
  target_t t1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start & ~busy;
  end
  always_ff @(posedge clk) t1 <= target;

  // stage 2: offset from shoulder and z limits
  logic                          v2;
  root_side_t                    s2;
  logic signed [COORD_WIDTH+1:0] z_lo_b;
  logic signed [COORD_WIDTH+1:0] z_hi_b;
  logic signed [COORD_WIDTH+1:0] z_w;
  always_comb begin
    z_w    = (COORD_WIDTH+2)'(t1.target_z);
    z_lo_b = (COORD_WIDTH+2)'(cfg.z_lo) - $signed((COORD_WIDTH+2)'(cfg.tol));
    z_hi_b = (COORD_WIDTH+2)'(cfg.z_hi) + $signed((COORD_WIDTH+2)'(cfg.tol));
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end
  always_ff @(posedge clk) begin
    s2.x    <= t1.target_x;
    s2.y    <= t1.target_y;
    s2.z    <= t1.target_z;
    s2.dz   <= delta_t'(t1.target_z) - delta_t'(cfg.shoulder);
    s2.zbad <= (z_w < z_lo_b) || (z_w > z_hi_b);
  end

  // stage 3: squares
  logic                  v3;
  root_side_t            s3;
  logic [2*ROOT_W-1:0]   sq_x, sq_y, sq_z;
  logic [ROOT_W-1:0]     m_x, m_y, m_z;
  always_comb begin
    m_x = s2.x[COORD_WIDTH-1] ? ROOT_W'(-delta_t'(s2.x)) : ROOT_W'(delta_t'(s2.x));
    m_y = s2.y[COORD_WIDTH-1] ? ROOT_W'(-delta_t'(s2.y)) : ROOT_W'(delta_t'(s2.y));
    m_z = s2.dz[COORD_WIDTH]  ? ROOT_W'(-s2.dz)          : ROOT_W'(s2.dz);
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end
  always_ff @(posedge clk) begin
    sq_x <= m_x * m_x;
    sq_y <= m_y * m_y;
    sq_z <= m_z * m_z;
    s3   <= s2;
  end

  // stage 4: sum of squares
  logic             v4;
  root_side_t       s4;
  logic [RAD_W-1:0] rad4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end
  always_ff @(posedge clk) begin
    rad4 <= sq_x + sq_y + sq_z;
    s4   <= s3;
  end

  logic              vr;
  logic [ROOT_W-1:0] reach_d;
  root_side_t        sr;

  arwc_sqrt u_sqrt (
    .clk, .rst,
    .in_valid (v4),
    .radicand (rad4),
    .in_side  (s4),
    .out_valid(vr),
    .root     (reach_d),
    .out_side (sr)
  );

  // stage 5: bounds and scale target
  logic              v5;
  root_side_t        s5;
  logic [ROOT_W-1:0] d5;
  logic [ROOT_W-2:0] t5;
  logic              scale5, oob5;
  logic [ROOT_W:0]   dmax, dmin, d_w, tol_w;
  logic              dbad, oob, do_scale, up;
  always_comb begin
    dmax     = (ROOT_W+1)'(cfg.l1) + (ROOT_W+1)'(cfg.l2);
    dmin     = (cfg.l1 >= cfg.l2) ? (ROOT_W+1)'(cfg.l1 - cfg.l2)
                                  : (ROOT_W+1)'(cfg.l2 - cfg.l1);
    d_w      = (ROOT_W+1)'(reach_d);
    tol_w    = (ROOT_W+1)'(cfg.tol);
    dbad     = (d_w + tol_w < dmin) || (d_w > dmax + tol_w);
    oob      = sr.zbad || dbad;
    up       = d_w > dmax;
    do_scale = oob && (reach_d != '0) && (d_w >= tol_w) && (up || (d_w < dmin));
  end
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= vr;
  end
  always_ff @(posedge clk) begin
    s5     <= sr;
    d5     <= reach_d;
    t5     <= up ? (ROOT_W-1)'(dmax) : (ROOT_W-1)'(dmin);
    scale5 <= do_scale;
    oob5   <= oob;
  end

  // stage 6: magnitude times target length
  logic                   v6;
  logic [2:0][PROD_W-1:0] p6;
  logic [ROOT_W-1:0]      d6;
  div_side_t              s6;
  logic [ROOT_W-1:0]      a_x, a_y, a_z;
  always_comb begin
    a_x = s5.x[COORD_WIDTH-1] ? ROOT_W'(-delta_t'(s5.x)) : ROOT_W'(delta_t'(s5.x));
    a_y = s5.y[COORD_WIDTH-1] ? ROOT_W'(-delta_t'(s5.y)) : ROOT_W'(delta_t'(s5.y));
    a_z = s5.dz[COORD_WIDTH]  ? ROOT_W'(-s5.dz)          : ROOT_W'(s5.dz);
  end
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
  end
  always_ff @(posedge clk) begin
    p6[0]    <= PROD_W'(a_x) * PROD_W'(t5);
    p6[1]    <= PROD_W'(a_y) * PROD_W'(t5);
    p6[2]    <= PROD_W'(a_z) * PROD_W'(t5);
    d6       <= d5;
    s6.x     <= s5.x;
    s6.y     <= s5.y;
    s6.z     <= s5.z;
    s6.neg_x <= s5.x[COORD_WIDTH-1];
    s6.neg_y <= s5.y[COORD_WIDTH-1];
    s6.neg_z <= s5.dz[COORD_WIDTH];
    s6.scale <= scale5;
    s6.oob   <= oob5;
  end

  logic                   vq;
  logic [2:0][PROD_W-1:0] q;
  div_side_t              sq;

  arwc_div u_div (
    .clk, .rst,
    .in_valid (v6),
    .num      (p6),
    .divisor  (d6),
    .in_side  (s6),
    .out_valid(vq),
    .quot     (q),
    .out_side (sq)
  );

  // final stage: sign, shoulder offset, saturation
  logic signed [SUM_W-1:0] r_x, r_y, r_z;
  always_comb begin
    logic signed [SUM_W-1:0] q_x, q_y, q_z;
    q_x = $signed({2'b00, q[0]});
    q_y = $signed({2'b00, q[1]});
    q_z = $signed({2'b00, q[2]});
    if (sq.scale) begin
      r_x = sq.neg_x ? -q_x : q_x;
      r_y = sq.neg_y ? -q_y : q_y;
      r_z = SUM_W'(cfg.shoulder) + (sq.neg_z ? -q_z : q_z);
    end else begin
      r_x = SUM_W'(sq.x);
      r_y = SUM_W'(sq.y);
      r_z = SUM_W'(sq.z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vq;
  end
  always_ff @(posedge clk) begin
    result.result_x      <= sat_coord(r_x);
    result.result_y      <= sat_coord(r_y);
    result.result_z      <= sat_coord(r_z);
    result.out_of_bounds <= sq.oob;
  end

endmodule

@@ hdl/arwc_regs.sv @@
// configuration registers behind the apb port
module arwc_regs
  import arwc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.l1       <= '0;
      cfg.l2       <= '0;
      cfg.shoulder <= '0;
      cfg.z_lo     <= {1'b1, {(COORD_WIDTH-1){1'b0}}};
      cfg.z_hi     <= {1'b0, {(COORD_WIDTH-1){1'b1}}};
      cfg.tol      <= TOL_W'(1);
    end else if (wr) begin
      case (idx)
        REG_LINK_ONE:  cfg.l1       <= pwdata[COORD_WIDTH-2:0];
        REG_LINK_TWO:  cfg.l2       <= pwdata[COORD_WIDTH-2:0];
        REG_SHOULDER:  cfg.shoulder <= pwdata[COORD_WIDTH-1:0];
        REG_Z_LOWER:   cfg.z_lo     <= pwdata[COORD_WIDTH-1:0];
        REG_Z_UPPER:   cfg.z_hi     <= pwdata[COORD_WIDTH-1:0];
        REG_TOLERANCE: cfg.tol      <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LINK_ONE:  prdata = 32'(cfg.l1);
      REG_LINK_TWO:  prdata = 32'(cfg.l2);
      REG_SHOULDER:  prdata = 32'($unsigned(cfg.shoulder));
      REG_Z_LOWER:   prdata = 32'($unsigned(cfg.z_lo));
      REG_Z_UPPER:   prdata = 32'($unsigned(cfg.z_hi));
      REG_TOLERANCE: prdata = 32'(cfg.tol);
      default:       prdata = '0;
    endcase
  end

endmodule

@@ hdl/arwc_sqrt.sv @@
// pipelined integer square root, one root bit per stage
module arwc_sqrt
  import arwc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  radicand,
  input  root_side_t        in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output root_side_t        out_side
);

  logic                vld  [ROOT_W+1];
  logic [RAD_W-1:0]    rad  [ROOT_W+1];
  logic [ROOT_W+1:0]   rem  [ROOT_W+1];
  logic [ROOT_W-1:0]   rt   [ROOT_W+1];
  root_side_t          side [ROOT_W+1];

  assign vld[0]  = in_valid;
  assign rad[0]  = radicand;
  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign side[0] = in_side;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [ROOT_W+1:0] cur;
    logic [ROOT_W+1:0] trial;
    logic              ge;

    // remainder stays below 2^(i+1), so the top two bits are free to shift out
    assign cur   = {rem[i][ROOT_W-1:0], rad[i][RAD_W-1 -: 2]};
    assign trial = {rt[i], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      rad[i+1]  <= rad[i] << 2;
      rem[i+1]  <= ge ? cur - trial : cur;
      rt[i+1]   <= {rt[i][ROOT_W-2:0], ge};
      side[i+1] <= side[i];
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

@@ hdl/arwc_div.sv @@
// three-lane pipelined restoring divider sharing one divisor, one quotient bit per stage
module arwc_div
  import arwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [2:0][PROD_W-1:0] num,
  input  logic [ROOT_W-1:0]      divisor,
  input  div_side_t              in_side,
  output logic                   out_valid,
  output logic [2:0][PROD_W-1:0] quot,
  output div_side_t              out_side
);

  logic                   vld  [PROD_W+1];
  logic [2:0][PROD_W-1:0] nm   [PROD_W+1];
  logic [2:0][ROOT_W-1:0] rm   [PROD_W+1];
  logic [ROOT_W-1:0]      dv   [PROD_W+1];
  div_side_t              side [PROD_W+1];

  assign vld[0]  = in_valid;
  assign nm[0]   = num;
  assign rm[0]   = '0;
  assign dv[0]   = divisor;
  assign side[0] = in_side;

  for (genvar i = 0; i < PROD_W; i++) begin : g_stage
    logic [2:0][ROOT_W-1:0] rm_next;
    logic [2:0][PROD_W-1:0] nm_next;

    always_comb begin
      logic [ROOT_W:0] cur;
      logic            ge;
      for (int l = 0; l < 3; l++) begin
        cur        = {rm[i][l], nm[i][l][PROD_W-1]};
        ge         = cur >= {1'b0, dv[i]};
        rm_next[l] = ge ? ROOT_W'(cur - {1'b0, dv[i]}) : ROOT_W'(cur);
        nm_next[l] = {nm[i][l][PROD_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      nm[i+1]   <= nm_next;
      rm[i+1]   <= rm_next;
      dv[i+1]   <= dv[i];
      side[i+1] <= side[i];
    end
  end

  assign out_valid = vld[PROD_W];
  assign quot      = nm[PROD_W];
  assign out_side  = side[PROD_W];

endmodule
